/* design/range_add_max_rise_segment_tree_unit_assert.svh */
`ifndef RANGE_ADD_MAX_RISE_SEGMENT_TREE_UNIT_ASSERT_SVH
`define RANGE_ADD_MAX_RISE_SEGMENT_TREE_UNIT_ASSERT_SVH

// check sampled on clk, off while rst is high
`define RAST_ASSERT_DIS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check sampled on clk, active during reset too
`define RAST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/rast_pkg.sv */
package rast_pkg;

  localparam int DEF_MAX_POSITIONS = 1024;
  localparam int POS_W = 11;
  localparam int VAL_W = 32;
  localparam int DW = 48;
  localparam logic signed [DW-1:0] EMPTY_MAG = 48'sh00003f3f3f3f;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_QUERY = 2'd2
  } mode_t;

  typedef struct packed {
    logic [DW-1:0]        fall;
    logic [DW-1:0]        rise;
    logic signed [DW-1:0] mn;
    logic signed [DW-1:0] mx;
  } summary_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_CLEAR,
    OP_START,
    OP_LATCH_CUR,
    OP_APPLY_TAG,
    OP_CLR_PEND,
    OP_APPLY_VAL,
    OP_LEAF,
    OP_LATCH_A,
    OP_PULL,
    OP_ACC_JOIN,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   rd_en;
  } dp_cmd_t;

  typedef struct packed {
    logic pend_nz;
  } dp_status_t;

endpackage

/* design/range_add_max_rise_segment_tree_unit.sv */
// Lazy segment tree over positions 1..used_size (clamped to 1..MAX_POSITIONS) with
// point load, range add and range query of max, min, best rise and best fall. The
// tree walk is recursive, held on a small frame stack, and every node visit goes
// through the single node memory (one write and one registered read per cycle):
// a visit tests a node, pushes a pending add down to the children when one is there,
// folds a covered node, and returns to its parent, where adds and loads recombine
// the two children; an add or query touches about 4*log2(n) nodes and a load
// one node per tree level. After reset the block sweeps all 4*MAX_POSITIONS
// nodes to zero, one per cycle, before s_tready first rises; configuration writes are
// taken during the sweep. Only queries produce a result transaction, and a finished
// result waits in the output register while the next transaction is accepted.
module range_add_max_rise_segment_tree_unit #(
  parameter int MAX_POSITIONS = rast_pkg::DEF_MAX_POSITIONS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [55:0]   s_tdata,   // left[10:0], right[21:11], value[53:22], zero pad
  input  logic [1:0]    s_tuser,   // mode
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [191:0]  m_tdata,   // range_max, range_min, best_rise, best_fall
  input  logic          cfg_we,
  input  logic [10:0]   cfg_wdata
);

  localparam int AW = $clog2(4 * MAX_POSITIONS);

  rast_pkg::dp_cmd_t    cmd;
  rast_pkg::dp_status_t status;
  rast_pkg::summary_t   result;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        wr_addr;

  rast_ctrl #(
    .MAX_POSITIONS(MAX_POSITIONS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_mode   (s_tuser),
    .in_left   (s_tdata[10:0]),
    .in_right  (s_tdata[21:11]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .status    (status),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr)
  );

  rast_datapath #(
    .MAX_POSITIONS(MAX_POSITIONS)
  ) u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .in_value (s_tdata[53:22]),
    .status   (status),
    .result   (result)
  );

  assign m_tdata = result;

endmodule

/* design/rast_datapath.sv */
module rast_datapath #(
  parameter int MAX_POSITIONS = rast_pkg::DEF_MAX_POSITIONS,
  localparam int DEPTH = 4 * MAX_POSITIONS,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                                  clk,
  input  rast_pkg::dp_cmd_t                     cmd,
  input  logic [AW-1:0]                         rd_addr,
  input  logic [AW-1:0]                         wr_addr,
  input  logic signed [rast_pkg::VAL_W-1:0]     in_value,
  output rast_pkg::dp_status_t                  status,
  output rast_pkg::summary_t                    result
);

  localparam int W = rast_pkg::DW;
  localparam int VW = rast_pkg::VAL_W;

  typedef struct packed {
    logic signed [W-1:0] pend;
    rast_pkg::summary_t  s;
  } node_t;

  function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] x,
                                                  input logic signed [W-1:0] y);
    logic signed [W:0] s;
    s = {x[W-1], x} + {y[W-1], y};
    if (s[W] != s[W-1]) begin
      sat_add = s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      sat_add = s[W-1:0];
    end
  endfunction

  function automatic node_t apply_add(input node_t nd, input logic signed [W-1:0] v);
    node_t o;
    o = nd;
    o.s.mx = sat_add(nd.s.mx, v);
    o.s.mn = sat_add(nd.s.mn, v);
    o.pend = sat_add(nd.pend, v);
    apply_add = o;
  endfunction

  function automatic rast_pkg::summary_t join_sum(input rast_pkg::summary_t a,
                                                  input rast_pkg::summary_t b);
    rast_pkg::summary_t s;
    logic signed [W+1:0] d_r;
    logic signed [W+1:0] d_f;
    logic [W-1:0]        m_r;
    logic [W-1:0]        m_f;
    s.mx = (a.mx > b.mx) ? a.mx : b.mx;
    s.mn = (a.mn < b.mn) ? a.mn : b.mn;
    m_r = (a.rise > b.rise) ? a.rise : b.rise;
    m_f = (a.fall > b.fall) ? a.fall : b.fall;
    d_r = {{2{b.mx[W-1]}}, b.mx} - {{2{a.mn[W-1]}}, a.mn};
    d_f = {{2{a.mx[W-1]}}, a.mx} - {{2{b.mn[W-1]}}, b.mn};
    s.rise = (d_r > $signed({2'b00, m_r})) ? d_r[W-1:0] : m_r;
    s.fall = (d_f > $signed({2'b00, m_f})) ? d_f[W-1:0] : m_f;
    join_sum = s;
  endfunction

  node_t               mem [DEPTH];
  node_t               rdata;
  node_t               cur;
  node_t               wdata;
  logic                we;
  rast_pkg::summary_t  ra;
  rast_pkg::summary_t  acc;
  rast_pkg::summary_t  ident;
  logic                have;
  logic signed [W-1:0] val;

  always_comb begin
    ident.mx = -rast_pkg::EMPTY_MAG;
    ident.mn = rast_pkg::EMPTY_MAG;
    ident.rise = '0;
    ident.fall = '0;
  end

  always_comb begin
    wdata = '0;
    we = 1'b0;
    unique case (cmd.op)
      rast_pkg::OP_CLEAR: begin
        we = 1'b1;
      end
      rast_pkg::OP_APPLY_TAG: begin
        we = 1'b1;
        wdata = apply_add(rdata, cur.pend);
      end
      rast_pkg::OP_CLR_PEND: begin
        we = 1'b1;
        wdata = cur;
        wdata.pend = '0;
      end
      rast_pkg::OP_APPLY_VAL: begin
        we = 1'b1;
        wdata = apply_add(rdata, val);
      end
      rast_pkg::OP_LEAF: begin
        we = 1'b1;
        wdata.pend = rdata.pend;
        wdata.s.mx = val;
        wdata.s.mn = val;
      end
      rast_pkg::OP_PULL: begin
        we = 1'b1;
        wdata.s = join_sum(ra, rdata.s);
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      rast_pkg::OP_START: begin
        val <= {{(W-VW){in_value[VW-1]}}, in_value};
        acc <= ident;
        have <= 1'b0;
      end
      rast_pkg::OP_LATCH_CUR: cur <= rdata;
      rast_pkg::OP_LATCH_A: ra <= rdata.s;
      rast_pkg::OP_ACC_JOIN: begin
        acc <= have ? join_sum(acc, rdata.s) : rdata.s;
        have <= 1'b1;
      end
      rast_pkg::OP_EMIT: result <= acc;
      default: begin
      end
    endcase
  end

  assign status.pend_nz = (rdata.pend != '0);

endmodule

/* design/rast_ctrl.sv */
module rast_ctrl #(
  parameter int MAX_POSITIONS = rast_pkg::DEF_MAX_POSITIONS,
  localparam int DEPTH = 4 * MAX_POSITIONS,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_mode,
  input  logic [rast_pkg::POS_W-1:0]    in_left,
  input  logic [rast_pkg::POS_W-1:0]    in_right,
  output logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          cfg_we,
  input  logic [rast_pkg::POS_W-1:0]    cfg_wdata,
  input  rast_pkg::dp_status_t          status,
  output rast_pkg::dp_cmd_t             cmd,
  output logic [AW-1:0]                 rd_addr,
  output logic [AW-1:0]                 wr_addr
);

  localparam int PW = rast_pkg::POS_W;
  localparam int SD = $clog2(MAX_POSITIONS) + 1;
  localparam int SPW = $clog2(SD + 1);
  localparam int IW = $clog2(SD);
  localparam logic PH_LEFT = 1'b0;
  localparam logic PH_BOTH = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ENTER, S_PUSH_CHK, S_PUSH_L, S_PUSH_R, S_PUSH_P,
    S_LEAF_WR, S_COV_WR, S_Q_ACC, S_RETURN, S_RESUME, S_PULL_RDR, S_PULL_WR,
    S_DONE
  } state_t;

  state_t          state;
  logic [AW-1:0]   clr_cnt;
  logic [PW-1:0]   used_size;
  logic [1:0]      mode;
  logic [PW-1:0]   pos_a;
  logic [PW-1:0]   pos_b;
  logic [AW-1:0]   cur_p;
  logic [PW-1:0]   cur_l;
  logic [PW-1:0]   cur_r;
  logic            cur_ph;
  logic [SPW-1:0]  sp;
  logic [SPW-1:0]  sp_dec;
  logic [AW-1:0]   stk_p [SD];
  logic [PW-1:0]   stk_l [SD];
  logic [PW-1:0]   stk_r [SD];
  logic            stk_ph [SD];

  logic [PW:0]     lr_sum;
  logic [PW-1:0]   mid;
  logic [AW-1:0]   lc;
  logic [AW-1:0]   rc;
  logic [PW-1:0]   n_eff;
  logic            accept;
  logic            is_load;
  logic            is_query;
  logic            outside;
  logic            covered;
  logic            do_desc;
  logic            desc_right;
  logic            desc_ph;
  logic            emit;

  assign lr_sum = {1'b0, cur_l} + {1'b0, cur_r};
  assign mid = lr_sum[PW:1];
  assign lc = {cur_p[AW-2:0], 1'b0};
  assign rc = {cur_p[AW-2:0], 1'b1};
  assign sp_dec = sp - SPW'(1);
  assign in_ready = (state == S_IDLE);
  assign accept = in_valid && in_ready;
  assign is_load = (mode == rast_pkg::MODE_LOAD);
  assign is_query = (mode == rast_pkg::MODE_QUERY);
  assign outside = (cur_r < pos_a) || (cur_l > pos_b);
  assign covered = (pos_a <= cur_l) && (cur_r <= pos_b);
  assign emit = (state == S_DONE) && is_query && (!out_valid || out_ready);

  always_comb begin
    if (used_size == '0) begin
      n_eff = PW'(1);
    end else if (32'(used_size) > MAX_POSITIONS) begin
      n_eff = PW'(MAX_POSITIONS);
    end else begin
      n_eff = used_size;
    end
  end

  assign do_desc = (state == S_PUSH_CHK && !status.pend_nz) || (state == S_PUSH_P) ||
                   (state == S_RESUME && cur_ph == PH_LEFT);
  assign desc_right = (state == S_RESUME) || (is_load && pos_a > mid);
  assign desc_ph = (state == S_RESUME || is_load) ? PH_BOTH : PH_LEFT;

  always_comb begin
    cmd.op = rast_pkg::OP_IDLE;
    cmd.rd_en = 1'b0;
    rd_addr = cur_p;
    wr_addr = cur_p;
    unique case (state)
      S_CLEAR: begin
        cmd.op = rast_pkg::OP_CLEAR;
        wr_addr = clr_cnt;
      end
      S_IDLE: begin
        if (accept) begin
          cmd.op = rast_pkg::OP_START;
        end
      end
      S_ENTER: cmd.rd_en = is_load || !outside;
      S_PUSH_CHK: begin
        cmd.op = rast_pkg::OP_LATCH_CUR;
        cmd.rd_en = status.pend_nz;
        rd_addr = lc;
      end
      S_PUSH_L: begin
        cmd.op = rast_pkg::OP_APPLY_TAG;
        wr_addr = lc;
        cmd.rd_en = 1'b1;
        rd_addr = rc;
      end
      S_PUSH_R: begin
        cmd.op = rast_pkg::OP_APPLY_TAG;
        wr_addr = rc;
      end
      S_PUSH_P: cmd.op = rast_pkg::OP_CLR_PEND;
      S_LEAF_WR: cmd.op = rast_pkg::OP_LEAF;
      S_COV_WR: cmd.op = rast_pkg::OP_APPLY_VAL;
      S_Q_ACC: cmd.op = rast_pkg::OP_ACC_JOIN;
      S_RESUME: begin
        cmd.rd_en = (cur_ph == PH_BOTH) && !is_query;
        rd_addr = lc;
      end
      S_PULL_RDR: begin
        cmd.op = rast_pkg::OP_LATCH_A;
        cmd.rd_en = 1'b1;
        rd_addr = rc;
      end
      S_PULL_WR: cmd.op = rast_pkg::OP_PULL;
      S_DONE: begin
        if (emit) begin
          cmd.op = rast_pkg::OP_EMIT;
        end
      end
      S_RETURN: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      used_size <= PW'(1);
      sp <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        used_size <= cfg_wdata;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (do_desc) begin
        sp <= sp + SPW'(1);
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (in_mode == rast_pkg::MODE_ADD || in_mode == rast_pkg::MODE_QUERY ||
                (in_mode == rast_pkg::MODE_LOAD && in_left != '0 && in_left <= n_eff)) begin
              state <= S_ENTER;
            end
            sp <= '0;
          end
        end
        S_ENTER: begin
          if (is_load) begin
            state <= (cur_l == cur_r) ? S_LEAF_WR : S_PUSH_CHK;
          end else if (outside) begin
            state <= S_RETURN;
          end else if (covered) begin
            state <= is_query ? S_Q_ACC : S_COV_WR;
          end else begin
            state <= S_PUSH_CHK;
          end
        end
        S_PUSH_CHK: state <= status.pend_nz ? S_PUSH_L : S_ENTER;
        S_PUSH_L: state <= S_PUSH_R;
        S_PUSH_R: state <= S_PUSH_P;
        S_PUSH_P: state <= S_ENTER;
        S_LEAF_WR: state <= S_RETURN;
        S_COV_WR: state <= S_RETURN;
        S_Q_ACC: state <= S_RETURN;
        S_RETURN: begin
          if (sp == '0) begin
            state <= S_DONE;
          end else begin
            sp <= sp_dec;
            state <= S_RESUME;
          end
        end
        S_RESUME: begin
          if (cur_ph == PH_LEFT) begin
            state <= S_ENTER;
          end else begin
            state <= is_query ? S_RETURN : S_PULL_RDR;
          end
        end
        S_PULL_RDR: state <= S_PULL_WR;
        S_PULL_WR: state <= S_RETURN;
        S_DONE: begin
          if (!is_query || emit) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode <= in_mode;
      pos_a <= in_left;
      pos_b <= in_right;
      cur_p <= AW'(1);
      cur_l <= PW'(1);
      cur_r <= n_eff;
    end else if (do_desc) begin
      stk_p[sp[IW-1:0]] <= cur_p;
      stk_l[sp[IW-1:0]] <= cur_l;
      stk_r[sp[IW-1:0]] <= cur_r;
      stk_ph[sp[IW-1:0]] <= desc_ph;
      cur_p <= desc_right ? rc : lc;
      cur_l <= desc_right ? mid + PW'(1) : cur_l;
      cur_r <= desc_right ? cur_r : mid;
    end else if (state == S_RETURN && sp != '0) begin
      cur_p <= stk_p[sp_dec[IW-1:0]];
      cur_l <= stk_l[sp_dec[IW-1:0]];
      cur_r <= stk_r[sp_dec[IW-1:0]];
      cur_ph <= stk_ph[sp_dec[IW-1:0]];
    end
  end

endmodule

/* design/rast_checker.sv */
`include "range_add_max_rise_segment_tree_unit_assert.svh"

module rast_checker (
  input logic          clk,
  input logic          rst,
  input logic          s_tvalid,
  input logic          s_tready,
  input logic [1:0]    s_tuser,
  input logic          m_tvalid,
  input logic          m_tready,
  input logic [191:0]  m_tdata
);

  `RAST_ASSERT_DIS(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result transaction dropped or changed while stalled")
  `RAST_ASSERT(a_rst_no_out, rst |=> !m_tvalid, "result valid right after reset")
  `RAST_ASSERT_DIS(a_sweep_busy, $fell(rst) |-> !s_tready, "input taken before the clearing sweep")
  `RAST_ASSERT_DIS(a_walk_busy, s_tvalid && s_tready && (s_tuser == rast_pkg::MODE_ADD || s_tuser == rast_pkg::MODE_QUERY) |=> !s_tready, "input taken during a tree walk")

endmodule

bind range_add_max_rise_segment_tree_unit rast_checker u_rast_checker (.*);

/* test/tb_range_add_max_rise_segment_tree_unit.sv */
`timescale 1ns / 1ps

module tb_range_add_max_rise_segment_tree_unit;

  localparam int NODES = 4 * rast_pkg::DEF_MAX_POSITIONS;
  localparam longint S48_MAX = 64'sh00007FFFFFFFFFFF;
  localparam longint S48_MIN = -64'sh0000800000000000;
  localparam longint U48_MAX = 64'sh0000FFFFFFFFFFFF;
  localparam int SETTLE = 600;

  typedef struct {
    longint hi;
    longint lo;
    longint up;
    longint down;
  } span_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [55:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [191:0] m_tdata;
  logic cfg_we = 0;
  logic [10:0] cfg_wdata = '0;

  longint seg_max [NODES];
  longint seg_min [NODES];
  longint seg_rise [NODES];
  longint seg_fall [NODES];
  longint seg_tag [NODES];
  int unsigned size_reg;
  span_t query_results [$];
  int errors = 0;
  bit quiet = 0;

  range_add_max_rise_segment_tree_unit u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic longint clip_s48(longint x);
    if (x > S48_MAX) return S48_MAX;
    if (x < S48_MIN) return S48_MIN;
    return x;
  endfunction

  function automatic longint clip_u48(longint x);
    if (x > U48_MAX) return U48_MAX;
    if (x < 0) return 0;
    return x;
  endfunction

  function automatic longint max_of3(longint a, longint b, longint c);
    longint m;
    m = a > b ? a : b;
    return m > c ? m : c;
  endfunction

  function automatic span_t merge_spans(span_t a, span_t b);
    span_t s;
    s.hi = a.hi > b.hi ? a.hi : b.hi;
    s.lo = a.lo < b.lo ? a.lo : b.lo;
    s.up = clip_u48(max_of3(a.up, b.up, b.hi - a.lo));
    s.down = clip_u48(max_of3(a.down, b.down, a.hi - b.lo));
    return s;
  endfunction

  function automatic span_t node_span(int p);
    span_t s;
    s.hi = seg_max[p];
    s.lo = seg_min[p];
    s.up = seg_rise[p];
    s.down = seg_fall[p];
    return s;
  endfunction

  function automatic void recompute(int p);
    span_t s;
    if (2 * p + 1 >= NODES) return;
    s = merge_spans(node_span(2 * p), node_span(2 * p + 1));
    seg_max[p] = s.hi;
    seg_min[p] = s.lo;
    seg_rise[p] = s.up;
    seg_fall[p] = s.down;
  endfunction

  function automatic void add_node(int p, longint v);
    if (p >= NODES) return;
    seg_max[p] = clip_s48(seg_max[p] + v);
    seg_min[p] = clip_s48(seg_min[p] + v);
    seg_tag[p] = clip_s48(seg_tag[p] + v);
  endfunction

  function automatic void spread_tag(int p);
    if (seg_tag[p] != 0) begin
      add_node(2 * p, seg_tag[p]);
      add_node(2 * p + 1, seg_tag[p]);
      seg_tag[p] = 0;
    end
  endfunction

  function automatic void set_leaf(int p, int l, int r, int pos, longint v);
    int mid;
    if (p >= NODES) return;
    if (l == r) begin
      seg_max[p] = v;
      seg_min[p] = v;
      seg_rise[p] = 0;
      seg_fall[p] = 0;
      return;
    end
    mid = (l + r) >> 1;
    spread_tag(p);
    if (pos <= mid) set_leaf(2 * p, l, mid, pos, v);
    else set_leaf(2 * p + 1, mid + 1, r, pos, v);
    recompute(p);
  endfunction

  function automatic void add_span(int p, int l, int r, int a, int b, longint v);
    int mid;
    if (p >= NODES || r < a || l > b) return;
    if (a <= l && r <= b) begin
      add_node(p, v);
      return;
    end
    mid = (l + r) >> 1;
    spread_tag(p);
    add_span(2 * p, l, mid, a, b, v);
    add_span(2 * p + 1, mid + 1, r, a, b, v);
    recompute(p);
  endfunction

  function automatic void gather(int p, int l, int r, int a, int b,
                                 ref span_t acc, ref bit have);
    int mid;
    if (p >= NODES || r < a || l > b) return;
    if (a <= l && r <= b) begin
      if (have) acc = merge_spans(acc, node_span(p));
      else begin
        acc = node_span(p);
        have = 1;
      end
      return;
    end
    mid = (l + r) >> 1;
    spread_tag(p);
    gather(2 * p, l, mid, a, b, acc, have);
    gather(2 * p + 1, mid + 1, r, a, b, acc, have);
  endfunction

  function automatic void predict_tree(rast_pkg::mode_t md, int a, int b, logic [31:0] raw);
    longint v;
    int n;
    span_t acc;
    bit have;
    v = longint'($signed(raw));
    n = size_reg < 1 ? 1 : (size_reg > rast_pkg::DEF_MAX_POSITIONS ?
                            rast_pkg::DEF_MAX_POSITIONS : size_reg);
    have = 0;
    if (md == rast_pkg::MODE_LOAD) begin
      if (a >= 1 && a <= n) set_leaf(1, 1, n, a, v);
    end else if (md == rast_pkg::MODE_ADD) begin
      add_span(1, 1, n, a, b, v);
    end else if (md == rast_pkg::MODE_QUERY) begin
      acc.hi = -longint'(rast_pkg::EMPTY_MAG);
      acc.lo = longint'(rast_pkg::EMPTY_MAG);
      acc.up = 0;
      acc.down = 0;
      gather(1, 1, n, a, b, acc, have);
      query_results.insert(query_results.size(), acc);
    end
  endfunction

  initial begin
    foreach (seg_max[i]) begin
      seg_max[i] = 0;
      seg_min[i] = 0;
      seg_rise[i] = 0;
      seg_fall[i] = 0;
      seg_tag[i] = 0;
    end
    size_reg = 1;
  end

  always @(negedge clk) begin
    int k;
    if (quiet) m_tready = 1;
    else begin
      m_tready = 1;
      k = $urandom_range(1, 40);
      repeat (k) @(negedge clk);
      if (!quiet) begin
        m_tready = 0;
        k = $urandom_range(1, 18);
        repeat (k) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    span_t e;
    logic [47:0] got [4];
    logic [47:0] want [4];
    if (!rst && m_tvalid && m_tready) begin
      if (query_results.size() == 0) begin
        $display("%0t: unexpected transaction %h", $time, m_tdata);
        errors++;
      end else begin
        e = query_results.pop_front();
        want[0] = e.hi[47:0];
        want[1] = e.lo[47:0];
        want[2] = e.up[47:0];
        want[3] = e.down[47:0];
        for (int i = 0; i < 4; i++) begin
          got[i] = m_tdata[48 * i +: 48];
          if (got[i] !== want[i]) begin
            $display("%0t: field %0d expected %h actual %h", $time, i, want[i], got[i]);
            errors++;
          end
        end
      end
    end
  end

  task automatic send_item(rast_pkg::mode_t md, int a, int b, logic [31:0] v);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      @(negedge clk);
      s_tvalid = 0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid = 1;
    s_tuser = md;
    s_tdata = {2'b00, v, b[10:0], a[10:0]};
    do @(posedge clk); while (!s_tready);
    predict_tree(md, a[10:0], b[10:0], v);
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid = 0;
    wait (query_results.size() == 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_size(int unsigned sz);
    drain();
    cfg_we = 1;
    cfg_wdata = sz[10:0];
    @(negedge clk);
    cfg_we = 0;
    size_reg = sz[10:0];
  endtask

  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 2) == 0) return $urandom;
    return $urandom_range(0, 2000) - 1000;
  endfunction

  task automatic load_all(int n);
    for (int i = 1; i <= n; i++) begin
      send_item(rast_pkg::MODE_LOAD, i, $urandom_range(0, 2047), pick_value());
    end
  endtask

  task automatic random_items(int n, int count, bit wild);
    int a, b, r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 19);
      if (wild && $urandom_range(0, 5) == 0) begin
        a = $urandom_range(0, 2047);
        b = $urandom_range(0, 2047);
      end else begin
        a = $urandom_range(1, n);
        b = $urandom_range(a, n);
        if ($urandom_range(0, 9) == 0) b = $urandom_range(1, n);
      end
      if (r < 8) send_item(rast_pkg::MODE_QUERY, a, b, $urandom);
      else if (r < 16) send_item(rast_pkg::MODE_ADD, a, b, pick_value());
      else if (r < 18) send_item(rast_pkg::MODE_LOAD, $urandom_range(1, n), b, pick_value());
      else if (r == 18) begin
        send_item(rast_pkg::MODE_LOAD, $urandom_range(n + 1, 2047) & 11'h7ff, b, $urandom);
      end
      else send_item(rast_pkg::mode_t'(2'd3), a, b, $urandom);
    end
  endtask

  task automatic test_directed();
    write_size(3);
    send_item(rast_pkg::MODE_LOAD, 1, 0, 32'h7fffffff);
    send_item(rast_pkg::MODE_LOAD, 2, 2047, 32'h80000000);
    send_item(rast_pkg::MODE_LOAD, 3, 0, 32'h0);
    send_item(rast_pkg::MODE_LOAD, 0, 0, 32'h12345678);
    send_item(rast_pkg::MODE_LOAD, 4, 0, 32'h12345678);
    send_item(rast_pkg::MODE_QUERY, 1, 3, 0);
    send_item(rast_pkg::MODE_QUERY, 1, 1, 0);
    send_item(rast_pkg::MODE_QUERY, 2, 2, 0);
    send_item(rast_pkg::MODE_QUERY, 3, 1, 0);
    send_item(rast_pkg::MODE_QUERY, 0, 2047, 0);
    send_item(rast_pkg::MODE_QUERY, 4, 2047, 0);
    send_item(rast_pkg::MODE_ADD, 2, 3, 32'h7fffffff);
    send_item(rast_pkg::MODE_QUERY, 1, 3, 0);
    send_item(rast_pkg::MODE_ADD, 0, 2047, 32'h80000000);
    send_item(rast_pkg::MODE_QUERY, 2, 3, 0);
    send_item(rast_pkg::MODE_ADD, 3, 2, 32'h55);
    send_item(rast_pkg::mode_t'(2'd3), 1, 3, 32'hffffffff);
    send_item(rast_pkg::MODE_LOAD, 2, 0, 32'hffffff00);
    send_item(rast_pkg::MODE_QUERY, 1, 3, 0);
  endtask

  task automatic test_size_zero();
    write_size(0);
    load_all(1);
    random_items(1, 30, 1);
  endtask

  task automatic test_mid_sizes();
    write_size(17);
    load_all(17);
    random_items(17, 120, 1);
    write_size(64);
    load_all(64);
    random_items(64, 50, 1);
    drain();
    random_items(64, 50, 1);
  endtask

  task automatic test_full_size();
    write_size(2047);
    load_all(200);
    random_items(200, 150, 0);
  endtask

  task automatic test_no_idle();
    write_size(5);
    quiet = 1;
    load_all(5);
    random_items(5, 60, 1);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_directed();
    test_size_zero();
    test_mid_sizes();
    test_full_size();
    test_no_idle();
    drain();
    if (errors == 0 && query_results.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #40ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
